@@ design/pcd_pkg.sv @@
`timescale 1ns / 1ps

package pcd_pkg;

	// Field widths of the channels.
	localparam int IN_COORD_W = 24;
	localparam int MIN_LEG_W  = 16;
	localparam int LEG_OUT_W  = 11;
	localparam int WRAP_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register reset values and the saturation limit of the wrap counter.
	localparam logic [MIN_LEG_W-1:0] MIN_LEG_RST  = 16'd16;
	localparam logic [LEG_OUT_W-1:0] MAX_LEGS_RST = 11'd1024;
	localparam logic [WRAP_W-1:0]    WRAP_MAX     = 16'hFFFF;

	typedef enum logic [0:0] {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEG  = 1'b0,
		REG_MAX_LEGS = 1'b1
	} cfg_reg_t;

	// Sign of an orientation determinant.
	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_CMP,
		ST_RD,
		ST_ON,
		ST_O3,
		ST_O4,
		ST_EVAL,
		ST_ANCHOR_WR,
		ST_FIN
	} state_t;

	// What the finishing step applies to the path state.
	typedef enum logic [2:0] {
		ACT_CLEAR,
		ACT_ANCHOR,
		ACT_SKIP,
		ACT_WRAP,
		ACT_APPEND
	} act_t;

	typedef struct packed {
		logic                 wrap_detected;
		logic                 point_taken;
		logic [WRAP_W-1:0]    wrap_total;
		logic [LEG_OUT_W-1:0] legs_held;
	} result_t;

endpackage

@@ design/pcd_in_if.sv @@
`timescale 1ns / 1ps

interface pcd_in_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic signed [pcd_pkg::IN_COORD_W-1:0] pos_x;
	logic signed [pcd_pkg::IN_COORD_W-1:0] pos_y;

	modport source (output valid, opcode, pos_x, pos_y, input ready);
	modport sink   (input valid, opcode, pos_x, pos_y, output ready);
endinterface

@@ design/pcd_out_if.sv @@
`timescale 1ns / 1ps

interface pcd_out_if;
	logic                              valid;
	logic                              ready;
	logic                              wrap_detected;
	logic                              point_taken;
	logic [pcd_pkg::WRAP_W-1:0]        wrap_total;
	logic [pcd_pkg::LEG_OUT_W-1:0]     legs_held;

	modport source (output valid, wrap_detected, point_taken, wrap_total, legs_held,
		input ready);
	modport sink   (input valid, wrap_detected, point_taken, wrap_total, legs_held,
		output ready);
endinterface

@@ design/pcd_cfg_if.sv @@
`timescale 1ns / 1ps

interface pcd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pcd_pkg::CFG_IDX_W-1:0]   index;
	logic [pcd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ design/pcd_ram.sv @@
`timescale 1ns / 1ps

module pcd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/pcd_orient.sv @@
`timescale 1ns / 1ps

module pcd_orient #(
	parameter int CB = 24
) (
	input  logic                 clk,
	input  logic signed [CB-1:0] p_x,
	input  logic signed [CB-1:0] p_y,
	input  logic signed [CB-1:0] q_x,
	input  logic signed [CB-1:0] q_y,
	input  logic signed [CB-1:0] r_x,
	input  logic signed [CB-1:0] r_y,
	output pcd_pkg::sign_t       sgn
);
	import pcd_pkg::*;

	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] dqx, dqy, drx, dry;
	logic signed [PW-1:0] m1_q, m2_q;

	assign dqx = DW'(q_x) - DW'(p_x);
	assign dqy = DW'(q_y) - DW'(p_y);
	assign drx = DW'(r_x) - DW'(p_x);
	assign dry = DW'(r_y) - DW'(p_y);

	// Both cross-product terms are registered; the sign follows next cycle.
	always_ff @(posedge clk) begin
		m1_q <= dqx * dry;
		m2_q <= dqy * drx;
	end

	always_comb begin
		if (m1_q > m2_q) begin
			sgn = SGN_POS;
		end else if (m1_q < m2_q) begin
			sgn = SGN_NEG;
		end else begin
			sgn = SGN_ZERO;
		end
	end
endmodule

@@ design/path_self_crossing_detector.sv @@
`timescale 1ns / 1ps
// Clear and anchor requests go straight to the result; an update tests the leg length by
// component, then a short one by squared length, and when two or more legs are stored
// scans them and stops early on a crossing: three determinants per point.
// One request is handled at a time; the next is taken once the FSM is idle.
// Reset clears the path, the wrap count and the registers to their defaults;
// the point ring is not cleared, as only written entries are ever read.
module path_self_crossing_detector #(
	parameter int LEG_CAPACITY = 1024,
	parameter int COORD_BITS   = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	pcd_in_if.sink    req,
	pcd_out_if.source rsp,
	pcd_cfg_if.sink   cfg
);
	import pcd_pkg::*;

	localparam int DEPTH = LEG_CAPACITY + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int LW    = (AW > LEG_OUT_W) ? AW : LEG_OUT_W;
	localparam int XW    = DW + MIN_LEG_W;

	state_t state_q, state_d;
	act_t   act_q;

	logic signed [CB-1:0] nx_q, ny_q, lx_q, ly_q;
	logic signed [CB-1:0] cx_q, cy_q, px_q, py_q;
	logic                 op_q, empty_q;
	logic [WRAP_W-1:0]    wrap_cnt_q;
	logic [AW-1:0]        head_q, legs_q, ptr_q, k_q;
	logic [MIN_LEG_W-1:0] min_q, axs_q, ays_q;
	logic [LEG_OUT_W-1:0] max_q;
	logic [2*MIN_LEG_W:0] sq_q;
	sign_t                on_prev_q, on_cur_q, d3_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic [IN_COORD_W+CB-1:0] ext_x, ext_y;
	logic signed [CB-1:0]     in_x, in_y;
	logic signed [DW-1:0]     dx, dy;
	logic [DW-1:0]            ax, ay;
	logic [XW-1:0]            ax_w, ay_w;
	logic                     long_leg;
	logic [MIN_LEG_W-1:0]     mop;
	logic [2*MIN_LEG_W-1:0]   sq_prod;
	logic [LW-1:0]            limit, legs_w;
	logic                     keep_none, at_limit;
	logic [AW:0]              wsum;
	logic [AW-1:0]            waddr, ptr_next, head_next;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [2*CB-1:0]          ram_wdata, ram_rdata;
	logic signed [CB-1:0]     rd_x, rd_y;
	logic signed [CB-1:0]     o_px, o_py, o_qx, o_qy, o_rx, o_ry;
	sign_t                    sgn;
	logic                     hit, fin_fire, start_scan_short;
	state_t                   append_state;
	logic [WRAP_W-1:0]        wrap_inc;

	function automatic logic in_box(input logic signed [CB-1:0] bpx, bpy, bqx, bqy, brx, bry);
		logic signed [CB-1:0] x0, x1, y0, y1;
		x0 = (bpx < bqx) ? bpx : bqx;
		x1 = (bpx < bqx) ? bqx : bpx;
		y0 = (bpy < bqy) ? bpy : bqy;
		y1 = (bpy < bqy) ? bqy : bpy;
		return (brx >= x0) && (brx <= x1) && (bry >= y0) && (bry <= y1);
	endfunction

	// Coordinates are read as two's complement in COORD_BITS bits.
	assign ext_x = {{CB{1'b0}}, req.pos_x};
	assign ext_y = {{CB{1'b0}}, req.pos_y};
	assign in_x  = ext_x[CB-1:0];
	assign in_y  = ext_y[CB-1:0];

	// Leg length against the minimum, first by component.
	assign dx   = DW'(nx_q) - DW'(lx_q);
	assign dy   = DW'(ny_q) - DW'(ly_q);
	assign ax   = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay   = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign ax_w = XW'(ax);
	assign ay_w = XW'(ay);
	assign long_leg = (ax_w >= XW'(min_q)) || (ay_w >= XW'(min_q));

	// One shared squarer for the squared-length test.
	always_comb begin
		case (state_q)
			ST_SQ_X: mop = axs_q;
			ST_SQ_Y: mop = ays_q;
			default: mop = min_q;
		endcase
	end
	assign sq_prod = mop * mop;
	assign start_scan_short = sq_q >= {1'b0, sq_prod};

	// Leg limit and ring addressing.
	assign limit     = (LW'(max_q) < LW'(LEG_CAPACITY)) ? LW'(max_q) : LW'(LEG_CAPACITY);
	assign legs_w    = LW'(legs_q);
	assign keep_none = (legs_q == '0) && (limit == '0);
	assign at_limit  = (legs_q != '0) && (legs_w >= limit);
	assign wsum      = (AW+1)'(head_q) + (AW+1)'(legs_q) + (AW+1)'(1);
	assign waddr     = (wsum >= (AW+1)'(DEPTH)) ? AW'(wsum - (AW+1)'(DEPTH)) : AW'(wsum);
	assign ptr_next  = (ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(ptr_q + AW'(1));
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : AW'(head_q + AW'(1));
	assign append_state = (legs_q == '0 && !keep_none) ? ST_ANCHOR_WR : ST_FIN;
	assign wrap_inc  = (wrap_cnt_q == WRAP_MAX) ? wrap_cnt_q : WRAP_W'(wrap_cnt_q + 1'b1);

	assign rd_x = ram_rdata[2*CB-1:CB];
	assign rd_y = ram_rdata[CB-1:0];

	// Crossing decision for leg (prev, cur) against the new leg.
	always_comb begin
		hit = ((on_prev_q == SGN_POS && on_cur_q == SGN_NEG)
			|| (on_prev_q == SGN_NEG && on_cur_q == SGN_POS))
			&& ((d3_q == SGN_POS && sgn == SGN_NEG) || (d3_q == SGN_NEG && sgn == SGN_POS));
		if (on_prev_q == SGN_ZERO && in_box(lx_q, ly_q, nx_q, ny_q, px_q, py_q)) begin
			hit = 1'b1;
		end
		if (on_cur_q == SGN_ZERO && in_box(lx_q, ly_q, nx_q, ny_q, cx_q, cy_q)) begin
			hit = 1'b1;
		end
		if (d3_q == SGN_ZERO && in_box(px_q, py_q, cx_q, cy_q, lx_q, ly_q)) begin
			hit = 1'b1;
		end
		if (sgn == SGN_ZERO && in_box(px_q, py_q, cx_q, cy_q, nx_q, ny_q)) begin
			hit = 1'b1;
		end
	end

	assign fin_fire = (state_q == ST_FIN) && (!res_valid_q || rsp.ready);

	// Next state and orientation unit operands.
	always_comb begin
		state_d = state_q;
		o_px = lx_q;
		o_py = ly_q;
		o_qx = nx_q;
		o_qy = ny_q;
		o_rx = rd_x;
		o_ry = rd_y;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (op_q == OP_CLEAR || empty_q) begin
					state_d = ST_FIN;
				end else if (!long_leg) begin
					state_d = ST_SQ_X;
				end else if (legs_q < AW'(2)) begin
					state_d = append_state;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_SQ_X: state_d = ST_SQ_Y;
			ST_SQ_Y: state_d = ST_SQ_CMP;
			ST_SQ_CMP: begin
				if (!start_scan_short) begin
					state_d = ST_FIN;
				end else if (legs_q < AW'(2)) begin
					state_d = append_state;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_ON;
			ST_ON: state_d = ST_O3;
			ST_O3: begin
				o_px = px_q;
				o_py = py_q;
				o_qx = cx_q;
				o_qy = cy_q;
				o_rx = lx_q;
				o_ry = ly_q;
				state_d = (k_q == '0) ? ST_RD : ST_O4;
			end
			ST_O4: begin
				o_px = px_q;
				o_py = py_q;
				o_qx = cx_q;
				o_qy = cy_q;
				o_rx = nx_q;
				o_ry = ny_q;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (hit) begin
					state_d = ST_FIN;
				end else if (k_q == AW'(legs_q - AW'(1))) begin
					state_d = append_state;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_ANCHOR_WR: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ring writes: the anchor point first, then each appended point.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = waddr;
		ram_wdata = {nx_q, ny_q};
		if (state_q == ST_ANCHOR_WR) begin
			ram_we    = 1'b1;
			ram_waddr = head_q;
			ram_wdata = {lx_q, ly_q};
		end else if (fin_fire && act_q == ACT_APPEND && !keep_none) begin
			ram_we = 1'b1;
		end
	end

	pcd_ram #(
		.WIDTH(2 * CB),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	pcd_orient #(
		.CB(CB)
	) u_orient (
		.clk(clk),
		.p_x(o_px),
		.p_y(o_py),
		.q_x(o_qx),
		.q_y(o_qy),
		.r_x(o_rx),
		.r_y(o_ry),
		.sgn(sgn)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_LEG_RST;
			max_q <= MAX_LEGS_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MIN_LEG:  min_q <= cfg.data;
				REG_MAX_LEGS: max_q <= cfg.data[LEG_OUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q <= req.opcode;
					nx_q <= in_x;
					ny_q <= in_y;
				end
			end
			ST_CHECK: begin
				axs_q <= ax_w[MIN_LEG_W-1:0];
				ays_q <= ay_w[MIN_LEG_W-1:0];
				ptr_q <= head_q;
				k_q   <= '0;
				if (op_q == OP_CLEAR) begin
					act_q <= ACT_CLEAR;
				end else if (empty_q) begin
					act_q <= ACT_ANCHOR;
				end else begin
					act_q <= ACT_APPEND;
				end
			end
			ST_SQ_X: sq_q <= (2*MIN_LEG_W+1)'(sq_prod);
			ST_SQ_Y: sq_q <= sq_q + (2*MIN_LEG_W+1)'(sq_prod);
			ST_SQ_CMP: begin
				if (!start_scan_short) begin
					act_q <= ACT_SKIP;
				end
			end
			ST_ON: begin
				cx_q <= rd_x;
				cy_q <= rd_y;
				px_q <= cx_q;
				py_q <= cy_q;
			end
			ST_O3: begin
				on_cur_q  <= sgn;
				on_prev_q <= on_cur_q;
				if (k_q == '0) begin
					ptr_q <= ptr_next;
					k_q   <= AW'(k_q + AW'(1));
				end
			end
			ST_O4: d3_q <= sgn;
			ST_EVAL: begin
				if (hit) begin
					act_q <= ACT_WRAP;
				end else begin
					ptr_q <= ptr_next;
					k_q   <= AW'(k_q + AW'(1));
				end
			end
			default: ;
		endcase
	end

	// Path state, applied when the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q       <= '0;
			ly_q       <= '0;
			empty_q    <= 1'b1;
			wrap_cnt_q <= '0;
			head_q     <= '0;
			legs_q     <= '0;
		end else if (fin_fire) begin
			case (act_q)
				ACT_CLEAR, ACT_WRAP: begin
					wrap_cnt_q <= (act_q == ACT_CLEAR) ? '0 : wrap_inc;
					lx_q    <= '0;
					ly_q    <= '0;
					empty_q <= 1'b1;
					head_q  <= '0;
					legs_q  <= '0;
				end
				ACT_ANCHOR, ACT_APPEND: begin
					lx_q    <= nx_q;
					ly_q    <= ny_q;
					empty_q <= 1'b0;
					if (act_q == ACT_APPEND && !keep_none) begin
						if (at_limit) begin
							head_q <= head_next;
						end else begin
							legs_q <= AW'(legs_q + AW'(1));
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_fire) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			res_q.wrap_detected <= (act_q == ACT_WRAP);
			res_q.point_taken   <= (act_q == ACT_ANCHOR) || (act_q == ACT_APPEND);
			case (act_q)
				ACT_CLEAR: begin
					res_q.wrap_total <= '0;
					res_q.legs_held  <= '0;
				end
				ACT_WRAP: begin
					res_q.wrap_total <= wrap_inc;
					res_q.legs_held  <= '0;
				end
				ACT_APPEND: begin
					res_q.wrap_total <= wrap_cnt_q;
					if (!keep_none && !at_limit) begin
						res_q.legs_held <= LEG_OUT_W'(legs_w + LW'(1));
					end else begin
						res_q.legs_held <= LEG_OUT_W'(legs_w);
					end
				end
				default: begin
					res_q.wrap_total <= wrap_cnt_q;
					res_q.legs_held  <= LEG_OUT_W'(legs_w);
				end
			endcase
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = res_valid_q;
	assign rsp.wrap_detected = res_q.wrap_detected;
	assign rsp.point_taken   = res_q.point_taken;
	assign rsp.wrap_total    = res_q.wrap_total;
	assign rsp.legs_held     = res_q.legs_held;
endmodule

@@ design/pcd_checker.sv @@
`timescale 1ns / 1ps

module pcd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            wrap_detected,
	input logic                            point_taken,
	input logic [pcd_pkg::WRAP_W-1:0]      wrap_total,
	input logic [pcd_pkg::LEG_OUT_W-1:0]   legs_held
);
	import pcd_pkg::*;

	logic                 out_fire;
	logic [WRAP_W-1:0]    prev_total_q;
	logic [LEG_OUT_W-1:0] prev_legs_q;

	assign out_fire = rsp_valid && rsp_ready;

	// Values of the previous result taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_total_q <= '0;
			prev_legs_q  <= '0;
		end else if (out_fire) begin
			prev_total_q <= wrap_total;
			prev_legs_q  <= legs_held;
		end
	end

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(wrap_total) && $stable(legs_held))
		else $error("result changed while stalled");

	// A wrap empties the path and never takes the point.
	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && wrap_detected |-> !point_taken && legs_held == '0)
		else $error("wrap left legs or took the point");

	// The wrap count moves only on a wrap, by one up to saturation, or back to zero on a clear.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !wrap_detected |-> wrap_total == prev_total_q || wrap_total == '0)
		else $error("wrap count moved without a wrap");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && wrap_detected |->
			(WRAP_W+1)'(wrap_total) == (WRAP_W+1)'(prev_total_q) + 1'b1
			|| (wrap_total == WRAP_MAX && prev_total_q == WRAP_MAX))
		else $error("wrap count did not step by one");

	// At most one leg is added per request.
	a_legs_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (LEG_OUT_W+1)'(legs_held) <= (LEG_OUT_W+1)'(prev_legs_q) + 1'b1)
		else $error("leg count grew by more than one");
endmodule

bind path_self_crossing_detector pcd_checker u_pcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.wrap_detected(rsp.wrap_detected),
	.point_taken  (rsp.point_taken),
	.wrap_total   (rsp.wrap_total),
	.legs_held    (rsp.legs_held)
);

@@ bench/tb_path_self_crossing_detector.sv @@
`timescale 1ns / 1ps

module tb_path_self_crossing_detector;
	import pcd_pkg::*;

	localparam int CAP_LEGS    = 1024;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	pcd_in_if  req_if ();
	pcd_out_if rsp_if ();
	pcd_cfg_if cfg_if ();

	path_self_crossing_detector uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Predicted track state and register copies.
	longint  tail_x, tail_y;
	bit      track_empty;
	int      wrap_count;
	int      leg_count;
	longint  vert_x[$], vert_y[$];
	int      min_leg_reg;
	int      max_legs_reg;

	result_t expected_results[$];
	int      fail_count;
	bit      req_up;
	bit      steady;
	bit      hold_rsp;
	int      idle_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int orient(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint d;
		d = (qx - px) * (ry - py) - (qy - py) * (rx - px);
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	function automatic bit in_box(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint x0, x1, y0, y1;
		x0 = (px < qx) ? px : qx;
		x1 = (px < qx) ? qx : px;
		y0 = (py < qy) ? py : qy;
		y1 = (py < qy) ? qy : py;
		return rx >= x0 && rx <= x1 && ry >= y0 && ry <= y1;
	endfunction

	// Segment intersection, touching and colinear overlap included.
	function automatic bit legs_meet(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy, longint dx, longint dy);
		int d1, d2, d3, d4;
		d1 = orient(cx, cy, dx, dy, ax, ay);
		d2 = orient(cx, cy, dx, dy, bx, by);
		d3 = orient(ax, ay, bx, by, cx, cy);
		d4 = orient(ax, ay, bx, by, dx, dy);
		if (d1 * d2 < 0 && d3 * d4 < 0)
			return 1'b1;
		if (d1 == 0 && in_box(cx, cy, dx, dy, ax, ay)) return 1'b1;
		if (d2 == 0 && in_box(cx, cy, dx, dy, bx, by)) return 1'b1;
		if (d3 == 0 && in_box(ax, ay, bx, by, cx, cy)) return 1'b1;
		if (d4 == 0 && in_box(ax, ay, bx, by, dx, dy)) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void drop_track();
		tail_x = 0;
		tail_y = 0;
		track_empty = 1'b1;
		leg_count = 0;
		vert_x.delete();
		vert_y.delete();
	endfunction

	// Works out the result of one request and advances the predicted track.
	function automatic result_t track_point(op_t op, longint x, longint y);
		result_t r;
		longint  ax, ay, mn;
		bit      hit;
		int      lim;
		r = '0;
		if (op == OP_CLEAR) begin
			wrap_count = 0;
			drop_track();
		end else if (track_empty) begin
			tail_x = x;
			tail_y = y;
			track_empty = 1'b0;
			r.point_taken = 1'b1;
		end else begin
			ax = (x > tail_x) ? x - tail_x : tail_x - x;
			ay = (y > tail_y) ? y - tail_y : tail_y - y;
			mn = min_leg_reg;
			if (!(ax < mn && ay < mn && ax * ax + ay * ay < mn * mn)) begin
				hit = 1'b0;
				for (int i = 0; i + 1 < leg_count && !hit; i++)
					hit = legs_meet(vert_x[i], vert_y[i], vert_x[i+1], vert_y[i+1],
						tail_x, tail_y, x, y);
				if (hit) begin
					r.wrap_detected = 1'b1;
					if (wrap_count < 65535)
						wrap_count++;
					drop_track();
				end else begin
					r.point_taken = 1'b1;
					lim = (max_legs_reg < CAP_LEGS) ? max_legs_reg : CAP_LEGS;
					if (!(leg_count == 0 && lim == 0)) begin
						if (leg_count == 0) begin
							vert_x = {tail_x};
							vert_y = {tail_y};
						end else if (leg_count >= lim) begin
							vert_x.delete(0);
							vert_y.delete(0);
							leg_count--;
						end
						vert_x = {vert_x, x};
						vert_y = {vert_y, y};
						leg_count++;
					end
					tail_x = x;
					tail_y = y;
				end
			end
		end
		r.wrap_total = wrap_count[WRAP_W-1:0];
		r.legs_held  = leg_count[LEG_OUT_W-1:0];
		return r;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rnd_coord();
		return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
	endfunction

	task automatic lower_req();
		if (req_up) begin
			req_if.valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	// Offers one request and records its expected result once it is taken.
	task automatic send_req(op_t op, int x, int y);
		logic signed [IN_COORD_W-1:0] sx, sy;
		int g;
		result_t exp_r;
		sx = x[IN_COORD_W-1:0];
		sy = y[IN_COORD_W-1:0];
		req_if.valid  <= 1'b1;
		req_if.opcode <= op;
		req_if.pos_x  <= sx;
		req_if.pos_y  <= sy;
		req_up = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		exp_r = track_point(op, longint'(sx), longint'(sy));
		expected_results = {expected_results, exp_r};
		g = pick_gap();
		if (g > 0) begin
			lower_req();
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		lower_req();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int value);
		wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == REG_MIN_LEG)
			min_leg_reg = value & 16'hFFFF;
		else
			max_legs_reg = value & 11'h7FF;
	endtask

	// A path monotone in x (a step may be zero) seldom crosses itself; optionally end on
	// a point thrown back across it.
	task automatic walk(int n, bit throw_back, output int sent);
		int x, y, x0, dir, stp;
		dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
		x0  = $urandom_range(0, 16000000) - 8000000;
		y   = $urandom_range(0, 16000000) - 8000000;
		x   = x0;
		sent = 0;
		for (int i = 0; i < n; i++) begin
			stp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
				: $urandom_range(1, 3000);
			x += dir * stp;
			y += $urandom_range(0, 10000) - 5000;
			send_req(OP_UPDATE, x, y);
			sent++;
		end
		if (throw_back) begin
			send_req(OP_UPDATE, x0 + dir * $urandom_range(0, (x - x0) * dir),
				($urandom_range(0, 1) != 0) ? 8388607 : -8388608);
			sent++;
		end
	endtask

	// Edge cases of the fields: anchoring, short legs, crossings, touching,
	// colinear overlap and the clear command.
	task automatic test_directed();
		send_req(OP_CLEAR, rnd_coord(), rnd_coord());
		send_req(OP_UPDATE, 0, 0);
		send_req(OP_UPDATE, 3, 4);
		send_req(OP_UPDATE, 1000, 0);
		send_req(OP_UPDATE, 1000, 1000);
		send_req(OP_UPDATE, 0, 1000);
		send_req(OP_UPDATE, 500, -500);
		send_req(OP_UPDATE, 8388607, 8388607);
		send_req(OP_UPDATE, -8388608, -8388608);
		send_req(OP_UPDATE, 8388607, -8388608);
		send_req(OP_UPDATE, -8388608, 8388607);
		send_req(OP_UPDATE, 0, 0);
		send_req(OP_UPDATE, 100, 0);
		send_req(OP_UPDATE, 100, 100);
		send_req(OP_UPDATE, 200, 0);
		send_req(OP_UPDATE, 0, 0);
		send_req(OP_UPDATE, 100, 0);
		send_req(OP_UPDATE, 200, 0);
		send_req(OP_UPDATE, 50, 0);
		send_req(OP_CLEAR, 8388607, -8388608);
		send_req(OP_UPDATE, -1, -1);
	endtask

	// Register extremes: zero and maximum leg length, limits of 0, 1 and
	// above capacity, and a lowered limit that trims only one leg at a time.
	task automatic test_registers();
		int n;
		write_reg(REG_MIN_LEG, 0);
		send_req(OP_CLEAR, 0, 0);
		send_req(OP_UPDATE, 10, 10);
		send_req(OP_UPDATE, 10, 10);
		send_req(OP_UPDATE, 20, 10);
		send_req(OP_UPDATE, 20, 10);
		send_req(OP_UPDATE, 30, 10);
		send_req(OP_UPDATE, 30, 10);
		write_reg(REG_MIN_LEG, 65535);
		send_req(OP_CLEAR, 0, 0);
		send_req(OP_UPDATE, 0, 0);
		send_req(OP_UPDATE, 40000, 40000);
		send_req(OP_UPDATE, 65535, 0);
		send_req(OP_UPDATE, 0, 65535);
		write_reg(REG_MIN_LEG, 16);
		write_reg(REG_MAX_LEGS, 1);
		walk(6, 1'b1, n);
		write_reg(REG_MAX_LEGS, 0);
		send_req(OP_CLEAR, 0, 0);
		walk(5, 1'b0, n);
		write_reg(REG_MAX_LEGS, 2047);
		walk(8, 1'b1, n);
		write_reg(REG_MAX_LEGS, 1024);
		walk(12, 1'b0, n);
		write_reg(REG_MAX_LEGS, 3);
		walk(4, 1'b1, n);
	endtask

	// A long path at the default limit, then a crossing.
	task automatic test_long_path();
		int n;
		write_reg(REG_MAX_LEGS, 1024);
		send_req(OP_CLEAR, 0, 0);
		walk(250, 1'b1, n);
	endtask

	// The receiver holds off while requests keep coming, then the sender waits for
	// every result before one more walk that ends on a thrown-back point.
	task automatic test_backpressure();
		int n;
		steady = 1'b1;
		hold_rsp = 1'b1;
		walk(8, 1'b0, n);
		steady = 1'b0;
		wait_drained();
		walk(6, 1'b1, n);
	endtask

	// Random paths with noise points and clears, over several settings.
	task automatic test_random();
		int min_vals[7] = '{0, 5, 16, 40, 100, 1, 16};
		int max_vals[7] = '{1, 2, 8, 30, 64, 1024, 40};
		int n, got, r;
		for (int p = 0; p < 7; p++) begin
			write_reg(REG_MIN_LEG, min_vals[p]);
			write_reg(REG_MAX_LEGS, max_vals[p]);
			steady = (p == 2);
			n = 0;
			while (n < 25) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					send_req(OP_UPDATE, rnd_coord(), rnd_coord());
					n++;
				end else if (r < 12) begin
					send_req(OP_CLEAR, rnd_coord(), rnd_coord());
					n++;
				end else begin
					walk($urandom_range(3, 30), $urandom_range(0, 1), got);
					n += got;
				end
			end
		end
		steady = 1'b0;
	endtask

	// Result checker.
	initial begin
		result_t got, want;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got.wrap_detected = rsp_if.wrap_detected;
				got.point_taken   = rsp_if.point_taken;
				got.wrap_total    = rsp_if.wrap_total;
				got.legs_held     = rsp_if.legs_held;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result wrap=%0b taken=%0b total=%0d legs=%0d",
						$time, got.wrap_detected, got.point_taken, got.wrap_total,
						got.legs_held);
					fail_count++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (got !== want) begin
						$display("%0t: expected wrap=%0b taken=%0b total=%0d legs=%0d, got wrap=%0b taken=%0b total=%0d legs=%0d",
							$time, want.wrap_detected, want.point_taken, want.wrap_total,
							want.legs_held, got.wrap_detected, got.point_taken,
							got.wrap_total, got.legs_held);
						fail_count++;
					end
				end
			end
		end
	end

	// Receiver ready: random stalls, and one long hold when asked.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_if.ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 99) < 10) begin
				rsp_if.ready <= 1'b0;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(20, 60)) @(posedge clk);
				else
					repeat ($urandom_range(1, 3)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no accepted transfer on any channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_path_self_crossing_detector: FAIL");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		req_if.valid  = 1'b0;
		req_if.opcode = OP_UPDATE;
		req_if.pos_x  = '0;
		req_if.pos_y  = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = REG_MIN_LEG;
		cfg_if.data   = '0;
		req_up = 1'b0;
		steady = 1'b0;
		hold_rsp = 1'b0;
		fail_count = 0;
		wrap_count = 0;
		min_leg_reg = 16;
		max_legs_reg = 1024;
		drop_track();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_registers();
		test_long_path();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb_path_self_crossing_detector: PASS");
		else
			$display("tb_path_self_crossing_detector: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/pcd_pkg.sv
design/pcd_in_if.sv
design/pcd_out_if.sv
design/pcd_cfg_if.sv
design/pcd_ram.sv
design/pcd_orient.sv
design/path_self_crossing_detector.sv
design/pcd_checker.sv
bench/tb_path_self_crossing_detector.sv
